@@ hw/rtl/lag_pkg.sv @@
// Package for the toroidal life automaton: grid sizes, request and result types, codes.
package lag_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int COL_W = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_W = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  // Width of the coordinate fields in a request.
  localparam int COORD_W = 6;
  localparam int COORD_N = 1 << COORD_W;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               write_value;
  } req_t;

  typedef struct packed {
    logic read_value;
    logic step_done;
  } rsp_t;

  // One grid row in both planes.
  typedef struct packed {
    logic [GRID_WIDTH-1:0] a;
    logic [GRID_WIDTH-1:0] b;
  } row_pair_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_STEP
  } state_t;

  // Coordinate reduction tables, built at elaboration.
  function automatic logic [COORD_N-1:0][COL_W-1:0] col_map_build();
    logic [COORD_N-1:0][COL_W-1:0] m;
    for (int i = 0; i < COORD_N; i++) begin
      m[i] = COL_W'(i % GRID_WIDTH);
    end
    return m;
  endfunction

  function automatic logic [COORD_N-1:0][ROW_W-1:0] row_map_build();
    logic [COORD_N-1:0][ROW_W-1:0] m;
    for (int i = 0; i < COORD_N; i++) begin
      m[i] = ROW_W'(i % GRID_HEIGHT);
    end
    return m;
  endfunction

  localparam logic [COORD_N-1:0][COL_W-1:0] COL_MAP = col_map_build();
  localparam logic [COORD_N-1:0][ROW_W-1:0] ROW_MAP = row_map_build();

endpackage

@@ hw/rtl/life_automaton_generation.sv @@
// Top level of the toroidal life automaton: ring of row cells, rule unit and control.
//
// Requests arrive on req (valid/ready) and carry an op code, a cell column and row,
// and a value to write. Results leave on rsp (valid/ready). A write produces no
// result, a read returns the cell value, a generation step returns step_done, and
// the unused op code is taken and dropped.
//
// The grid lives in a ring of GRID_HEIGHT row cells, each holding one row of both
// planes. The ring rotates by one row per cycle when it moves, and all access goes
// through the row at the head of the ring. A read or write waits until the wanted
// row reaches the head. A step rotates the ring once all the way round, computing
// one new row per cycle, and then returns its result. One request is in work at a
// time; req_ready is high only when the block is idle and no result waits.
//
// Reset clears both planes to dead and makes plane a current. When the receiver
// stalls, the result stays in rsp with rsp_valid high and no new request is taken.
module life_automaton_generation
  import lag_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_HEIGHT - 1);

  state_t state;
  state_t state_next;

  row_pair_t cell_row [GRID_HEIGHT];
  row_pair_t wrap_in;
  logic      shift;

  // Logical row currently sitting in the head cell.
  logic [ROW_W-1:0] head_row;
  logic [ROW_W-1:0] target_row;
  logic [COL_W-1:0] target_col;
  logic [1:0]       op_q;
  logic             write_value;
  logic [ROW_W-1:0] step_cnt;
  logic             active;

  logic                  req_fire;
  logic                  at_target;
  logic                  step_last;
  logic                  rsp_load;
  rsp_t                  rsp_next;
  logic                  flip;
  logic [GRID_WIDTH-1:0] head_cur;
  logic [GRID_WIDTH-1:0] up_cur;
  logic [GRID_WIDTH-1:0] down_cur;
  logic [GRID_WIDTH-1:0] new_row;

  assign req_ready = (state == ST_IDLE) && !rsp_valid;
  assign req_fire  = req_valid && req_ready;
  assign at_target = (head_row == target_row);
  assign step_last = (step_cnt == LAST_ROW);

  // The ring: each cell takes the row of the cell after it, and the last cell takes
  // the head row as modified by the current operation.
  for (genvar i = 0; i < GRID_HEIGHT; i++) begin : g_cell
    row_pair_t cell_in;
    if (i == GRID_HEIGHT - 1) begin : g_wrap
      assign cell_in = wrap_in;
    end else begin : g_link
      assign cell_in = cell_row[i+1];
    end
    lag_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .shift_in (cell_in),
      .row_out  (cell_row[i])
    );
  end

  // The previous logical row sits in the last cell, the next one in cell 1.
  assign head_cur = active ? cell_row[0].b : cell_row[0].a;
  assign up_cur   = active ? cell_row[GRID_HEIGHT-1].b : cell_row[GRID_HEIGHT-1].a;
  assign down_cur = active ? cell_row[1].b : cell_row[1].a;

  lag_rule u_rule (
    .up       (up_cur),
    .mid      (head_cur),
    .down     (down_cur),
    .next_row (new_row)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_fire) begin
          case (req.op)
            OP_WRITE: state_next = ST_SEEK;
            OP_READ:  state_next = ST_SEEK;
            OP_STEP:  state_next = ST_STEP;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SEEK: begin
        if (at_target) begin
          state_next = ST_IDLE;
        end
      end
      ST_STEP: begin
        if (step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    shift    = 1'b0;
    wrap_in  = cell_row[0];
    rsp_load = 1'b0;
    rsp_next = '0;
    flip     = 1'b0;
    case (state)
      ST_SEEK: begin
        if (at_target) begin
          if (op_q == OP_WRITE) begin
            // Write the bit into the current plane as the head row moves on.
            shift = 1'b1;
            if (active) begin
              wrap_in.b[target_col] = write_value;
            end else begin
              wrap_in.a[target_col] = write_value;
            end
          end else begin
            rsp_load            = 1'b1;
            rsp_next.read_value = head_cur[target_col];
          end
        end else begin
          shift = 1'b1;
        end
      end
      ST_STEP: begin
        // The new generation of the head row goes into the other plane.
        shift = 1'b1;
        if (active) begin
          wrap_in.a = new_row;
        end else begin
          wrap_in.b = new_row;
        end
        if (step_last) begin
          flip               = 1'b1;
          rsp_load           = 1'b1;
          rsp_next.step_done = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head_row  <= '0;
      active    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (shift) begin
        head_row <= (head_row == LAST_ROW) ? '0 : head_row + 1'b1;
      end
      if (flip) begin
        active <= ~active;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q        <= req.op;
      target_col  <= COL_MAP[req.col];
      target_row  <= ROW_MAP[req.row];
      write_value <= req.write_value;
      step_cnt    <= '0;
    end else if (state == ST_STEP) begin
      step_cnt <= step_cnt + 1'b1;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ hw/rtl/lag_cell.sv @@
// One row cell of the ring: holds a grid row of both planes and takes its neighbor's row.
module lag_cell
  import lag_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  row_pair_t shift_in,
  output row_pair_t row_out
);

  row_pair_t row_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_q <= '0;
    end else if (shift) begin
      row_q <= shift_in;
    end
  end

  assign row_out = row_q;

endmodule

@@ hw/rtl/lag_rule.sv @@
// Life rule applied across one row, with the three source rows wrapping at the column edges.
module lag_rule
  import lag_pkg::*;
(
  input  logic [GRID_WIDTH-1:0] up,
  input  logic [GRID_WIDTH-1:0] mid,
  input  logic [GRID_WIDTH-1:0] down,
  output logic [GRID_WIDTH-1:0] next_row
);

  for (genvar j = 0; j < GRID_WIDTH; j++) begin : g_col
    localparam int JL = (j + GRID_WIDTH - 1) % GRID_WIDTH;
    localparam int JR = (j + 1) % GRID_WIDTH;
    logic [3:0] cnt;

    assign cnt = 4'(up[JL]) + 4'(up[j]) + 4'(up[JR])
               + 4'(mid[JL]) + 4'(mid[JR])
               + 4'(down[JL]) + 4'(down[j]) + 4'(down[JR]);
    assign next_row[j] = (cnt == 4'd3) || (mid[j] && (cnt == 4'd2));
  end

endmodule
